### design/mtep_pkg.sv
// shared types and constants for the midi track event parser
`timescale 1ns / 1ps
`default_nettype none

package mtep_pkg;

   localparam int unsigned DeltaWidth = 28;

   // status codes with special handling
   localparam logic [7:0] STATUS_META  = 8'hFF;
   localparam logic [7:0] STATUS_SYSEX = 8'hF0;

   // channel message kinds (status high nibble)
   localparam logic [3:0] KIND_NOTE_OFF     = 4'd8;
   localparam logic [3:0] KIND_NOTE_ON      = 4'd9;
   localparam logic [3:0] KIND_PROGRAM      = 4'd12;
   localparam logic [3:0] KIND_CHAN_PRESS   = 4'd13;
   localparam logic [3:0] KIND_PITCH_BEND   = 4'd14;

   // one decoded channel event
   typedef struct packed {
      logic [DeltaWidth-1:0] delta_ticks;
      logic [3:0]            event_kind;
      logic [3:0]            channel;
      logic [7:0]            first_arg;
      logic [7:0]            second_arg;
   } rsp_type;

endpackage

`default_nettype wire

### design/mtep_parser.sv
// byte-wise track parser: parse state registers and next-state/event logic
`timescale 1ns / 1ps
`default_nettype none

module mtep_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_en,
   input  wire logic [7:0]       data_byte,
   input  wire logic             track_start,
   output logic                  rsp_hit,
   output mtep_pkg::rsp_type     rsp_data
);
   import mtep_pkg::*;

   typedef enum logic [2:0] {
      PH_DELTA,
      PH_STATUS,
      PH_ARG1,
      PH_ARG2,
      PH_META_TYPE,
      PH_LEN,
      PH_SKIP_BYTES,
      PH_SKIP_DATA
   } phase_type;

   phase_type             phase_ff, phase_in, ph;
   logic [DeltaWidth-1:0] acc_ff, acc_in, acc;
   logic [1:0]            cnt_ff, cnt_in, cnt;
   logic [7:0]            run_ff, run_in, run;
   logic [7:0]            cur_ff, cur_in, cur;
   logic [7:0]            held_ff, held_in, held;
   logic [DeltaWidth-1:0] skip_ff, skip_in, skip;

   logic [7:0]            stat;
   logic [3:0]            stat_kind;
   logic                  kind_ok;
   logic [DeltaWidth-1:0] acc_shift;
   logic [DeltaWidth-1:0] len_shift;
   logic [DeltaWidth-1:0] skip_dec;
   logic [1:0]            cnt_inc;
   logic                  vlq_end;
   logic [7:0]            second;
   logic [3:0]            out_kind;

   // messages with a single data byte
   function automatic logic one_arg(input logic [7:0] status);
      logic [3:0] k;
      k = status[7:4];
      return (k == KIND_PROGRAM) || (k == KIND_CHAN_PRESS);
   endfunction

   // start of track clears the parser before the beat is used
   always_comb begin
      if (track_start) begin
         ph   = PH_DELTA;
         acc  = '0;
         cnt  = '0;
         run  = '0;
         cur  = '0;
         held = '0;
         skip = '0;
      end else begin
         ph   = phase_ff;
         acc  = acc_ff;
         cnt  = cnt_ff;
         run  = run_ff;
         cur  = cur_ff;
         held = held_ff;
         skip = skip_ff;
      end
   end

   // shared datapath terms
   assign stat      = data_byte[7] ? data_byte : run;
   assign stat_kind = stat[7:4];
   assign kind_ok   = (stat_kind >= KIND_NOTE_OFF) && (stat_kind <= KIND_PITCH_BEND);
   assign acc_shift = {acc[DeltaWidth-8:0], data_byte[6:0]};
   assign len_shift = {skip[DeltaWidth-8:0], data_byte[6:0]};
   assign skip_dec  = skip - DeltaWidth'(1);
   assign cnt_inc   = cnt + 2'd1;
   assign vlq_end   = !data_byte[7] || (cnt_inc == 2'd0);

   // next state and event detection
   always_comb begin
      phase_in = ph;
      acc_in   = acc;
      cnt_in   = cnt;
      run_in   = run;
      cur_in   = cur;
      held_in  = held;
      skip_in  = skip;
      rsp_hit  = 1'b0;
      second   = '0;

      unique case (ph)
         PH_STATUS: begin
            if (data_byte == STATUS_META) begin
               phase_in = PH_META_TYPE;
            end else if (data_byte == STATUS_SYSEX) begin
               phase_in = PH_LEN;
               cnt_in   = '0;
               skip_in  = '0;
            end else if (!kind_ok) begin
               phase_in = PH_SKIP_DATA;
            end else begin
               cur_in = stat;
               run_in = stat;
               if (data_byte[7]) begin
                  phase_in = PH_ARG1;
               end else begin
                  held_in = data_byte;
                  if (one_arg(stat)) begin
                     rsp_hit = 1'b1;
                  end else begin
                     phase_in = PH_ARG2;
                  end
               end
            end
         end
         PH_ARG1: begin
            held_in = data_byte;
            if (one_arg(cur)) begin
               rsp_hit = 1'b1;
            end else begin
               phase_in = PH_ARG2;
            end
         end
         PH_ARG2: begin
            second  = data_byte;
            rsp_hit = 1'b1;
         end
         PH_META_TYPE: begin
            phase_in = PH_LEN;
            cnt_in   = '0;
            skip_in  = '0;
         end
         PH_LEN: begin
            skip_in = len_shift;
            cnt_in  = cnt_inc;
            if (vlq_end) begin
               if (len_shift == '0) begin
                  phase_in = PH_DELTA;
                  acc_in   = '0;
                  cnt_in   = '0;
               end else begin
                  phase_in = PH_SKIP_BYTES;
               end
            end
         end
         PH_SKIP_BYTES: begin
            skip_in = skip_dec;
            if (skip_dec == '0) begin
               phase_in = PH_DELTA;
               acc_in   = '0;
               cnt_in   = '0;
            end
         end
         PH_SKIP_DATA: begin
            // a status-like byte opens the next delta time
            if (data_byte[7]) begin
               phase_in = PH_DELTA;
               acc_in   = {{(DeltaWidth-7){1'b0}}, data_byte[6:0]};
               cnt_in   = 2'd1;
            end
         end
         default: begin
            acc_in = acc_shift;
            cnt_in = cnt_inc;
            if (vlq_end) begin
               phase_in = PH_STATUS;
            end
         end
      endcase

      // a finished message returns to the delta time
      if (rsp_hit) begin
         phase_in = PH_DELTA;
         acc_in   = '0;
         cnt_in   = '0;
      end
   end

   // event fields
   always_comb begin
      out_kind = cur_in[7:4];
      if (out_kind == KIND_NOTE_ON && second == 8'd0) begin
         out_kind = KIND_NOTE_OFF;
      end
      rsp_data.delta_ticks = acc;
      rsp_data.event_kind  = out_kind;
      rsp_data.channel     = cur_in[3:0];
      rsp_data.first_arg   = held_in;
      rsp_data.second_arg  = second;
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DELTA;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         run_ff   <= '0;
         cur_ff   <= '0;
         held_ff  <= '0;
         skip_ff  <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         run_ff   <= run_in;
         cur_ff   <= cur_in;
         held_ff  <= held_in;
         skip_ff  <= skip_in;
      end
   end

   // checks
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      step_en && rsp_hit |-> rsp_data.event_kind >= KIND_NOTE_OFF
                          && rsp_data.event_kind <= KIND_PITCH_BEND)
      else $error("event kind out of range");

   a_event_to_delta: assert property (@(posedge clock) disable iff (reset)
      step_en && rsp_hit |=> phase_ff == PH_DELTA && acc_ff == '0 && cnt_ff == 2'd0)
      else $error("parser did not return to delta after event");

   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP_BYTES |-> skip_ff != '0)
      else $error("skip phase with zero byte count");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(phase_ff) && $stable(run_ff))
      else $error("parse state moved without a beat");

endmodule

`default_nettype wire

### design/mtep_rsp_reg.sv
// result register between the parser and the event channel
`timescale 1ns / 1ps
`default_nettype none

module mtep_rsp_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_en,
   input  wire logic             rsp_hit,
   input  mtep_pkg::rsp_type     rsp_data,
   output logic                  advance,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mtep_pkg::rsp_type     rsp_out
);
   import mtep_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   // register can load when empty or being drained
   assign advance   = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_out   = data_ff;

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= step_en && rsp_hit;
      end
   end

   // event beat payload
   always_ff @(posedge clock) begin
      if (advance && step_en && rsp_hit) begin
         data_ff <= rsp_data;
      end
   end

endmodule

`default_nettype wire

### design/midi_track_event_parser_core.sv
// top level of the midi track event parser: input register, parser, result register
// a byte beat in the input register passes through the parser into the result register
// one byte per cycle unless stalled; the input register frees when the result register can load
// a stalled result holds the input register and, behind it, the request channel
// synchronous active-high reset clears running status, parse phase and both valid flags
`timescale 1ns / 1ps
`default_nettype none

module midi_track_event_parser_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_track_start,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [27:0]      rsp_delta_ticks,
   output logic [3:0]       rsp_event_kind,
   output logic [3:0]       rsp_channel,
   output logic [7:0]       rsp_first_arg,
   output logic [7:0]       rsp_second_arg
);
   import mtep_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       advance;
   logic       step_en;
   logic       rsp_hit;
   rsp_type    rsp_data;
   rsp_type    rsp_out;

   // input register takes a beat whenever it is empty or being consumed
   assign step_en   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_track_start;
      end
   end

   // parser
   mtep_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .data_byte   (in_byte_ff),
      .track_start (in_start_ff),
      .rsp_hit     (rsp_hit),
      .rsp_data    (rsp_data)
   );

   // result register
   mtep_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .rsp_hit   (rsp_hit),
      .rsp_data  (rsp_data),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_out   (rsp_out)
   );

   assign rsp_delta_ticks = rsp_out.delta_ticks;
   assign rsp_event_kind  = rsp_out.event_kind;
   assign rsp_channel     = rsp_out.channel;
   assign rsp_first_arg   = rsp_out.first_arg;
   assign rsp_second_arg  = rsp_out.second_arg;

endmodule

`default_nettype wire
